FILE: src/tlil_pkg.sv
// Shared types and constants for the timed line index lookup block.
// Depends on nothing; every other file in src imports it.
package tlil_pkg;

   // Table depth default and the fixed field widths of the channels.
   // The result fields are seven bits wide, which holds DEPTH up to 64.
   localparam int TLIL_DEPTH = 64;
   localparam int STAMP_W    = 30;
   localparam int LINE_W     = 7;
   localparam int COUNT_W    = 7;
   localparam int POS_W      = 32;
   localparam int MUL_A_W    = 14;
   localparam int MUL_B_W    = 16;

   localparam logic [MUL_B_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [MUL_B_W-1:0] MS_PER_SECOND = 16'd1000;
   localparam logic [MUL_B_W-1:0] MS_PER_MS     = 16'd1;
   localparam logic [6:0]         MAX_SECONDS   = 7'd59;

   // Operation codes carried in the func field.
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [13:0]      minutes;
      logic [6:0]       seconds;
      logic [9:0]       millis;
      logic [POS_W-1:0] position_ms;
   } req_data_type;

   typedef struct packed {
      logic signed [LINE_W-1:0] line_index;
      logic                     changed;
      logic                     accepted;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_MAC,
      ALU_CMP,
      ALU_CLR
   } alu_op_type;

   typedef enum logic [1:0] {
      SEL_MIN,
      SEL_SEC,
      SEL_MS
   } alu_sel_type;

   typedef struct packed {
      alu_op_type  op;
      alu_sel_type sel;
   } alu_ctrl_type;

endpackage

FILE: src/tlil_ram.sv
// Timestamp store: one write port and one read port with registered read data.
// Depends on tlil_pkg for the stamp width.
module tlil_ram import tlil_pkg::*; #(
   parameter int DEPTH = TLIL_DEPTH,
   parameter int AW    = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [STAMP_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [STAMP_W-1:0] rd_data
);

   logic [STAMP_W-1:0] mem_ff [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tlil_alu.sv
// Shared arithmetic unit: a multiply-accumulate that builds a timestamp in
// three steps, and a compare-and-count used while scanning the table.
// Depends on tlil_pkg for the control struct and widths.
module tlil_alu import tlil_pkg::*; #(
   parameter int CW = 7
) (
   input  logic               clock,
   input  alu_ctrl_type       ctrl,
   input  req_data_type       operands,
   input  logic [STAMP_W-1:0] stamp_q,
   output logic [STAMP_W-1:0] acc,
   output logic [CW-1:0]      hits
);

   logic [STAMP_W-1:0] acc_ff;
   logic [STAMP_W-1:0] acc_in;
   logic [CW-1:0]      hits_ff;
   logic [CW-1:0]      hits_in;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [STAMP_W-1:0] prod;

   always_comb begin
      unique case (ctrl.sel)
         SEL_MIN: begin
            op_a = operands.minutes;
            op_b = MS_PER_MINUTE;
         end
         SEL_SEC: begin
            op_a = MUL_A_W'(operands.seconds);
            op_b = MS_PER_SECOND;
         end
         SEL_MS: begin
            op_a = MUL_A_W'(operands.millis);
            op_b = MS_PER_MS;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = STAMP_W'(op_a * op_b);

   always_comb begin
      acc_in  = acc_ff;
      hits_in = hits_ff;
      unique case (ctrl.op)
         ALU_MUL: acc_in = prod;
         // The sum wraps at the stamp width, though valid seconds keep it in range.
         ALU_MAC: acc_in = acc_ff + prod;
         ALU_CMP: begin
            if (POS_W'(stamp_q) <= operands.position_ms) begin
               hits_in = hits_ff + CW'(1);
            end
         end
         ALU_CLR:  hits_in = '0;
         ALU_IDLE: ;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      hits_ff <= hits_in;
   end

   assign acc  = acc_ff;
   assign hits = hits_ff;

endmodule

FILE: src/timed_line_index_lookup_top.sv
// Timed line index lookup. Keeps a table of up to DEPTH line start times in
// milliseconds and answers which line is current at a playback position.
// Request channel (req_): one beat per item, func selects clear, add or query.
// Response channel (rsp_): exactly one beat per request, in request order.
// Sequence from acceptance to rsp_valid: clear, unused codes, rejected adds
// and queries on an empty table go straight to the response register; an
// accepted add makes three passes through the shared multiplier, then one
// table write; a query reads the N stored entries one entry per cycle through
// the single read port, counting in the shared compare unit, then completes
// the last compare before the response is formed.
// req_stall is high while an item is in progress; one item is worked on at a
// time. The result sits in an output register, so the next request is taken
// as soon as the sequencer is free even while rsp_stall holds the last beat.
// A new request is therefore taken only after the previous one is done.
// A finished item waits in the sequencer only while rsp_stall holds the
// response register. Synchronous reset empties the table count and sets the
// current line to -1; the table contents are not cleared and need not be.
// Depends on tlil_pkg, tlil_ram and tlil_alu. DEPTH may range from 2 to 64.
module timed_line_index_lookup_top import tlil_pkg::*; #(
   parameter int DEPTH = TLIL_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = AW + 1;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MIN   = 8'b0000_0010,
      S_SEC   = 8'b0000_0100,
      S_MS    = 8'b0000_1000,
      S_WRITE = 8'b0001_0000,
      S_SCAN  = 8'b0010_0000,
      S_DRAIN = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   req_data_type         req_ff, req_in;
   logic                 ok_ff, ok_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [LW-1:0] cur_ff, cur_in;
   logic                 cmp_pending_ff, cmp_pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_data_type         rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 ram_we;
   logic [STAMP_W-1:0]   ram_q;
   logic [STAMP_W-1:0]   alu_acc;
   logic [CW-1:0]        alu_hits;
   alu_ctrl_type         alu_ctrl;
   logic signed [LW-1:0] idx;
   logic                 changed;
   logic                 accepted;

   tlil_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (alu_acc),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   tlil_alu #(
      .CW (CW)
   ) u_alu (
      .clock    (clock),
      .ctrl     (alu_ctrl),
      .operands (req_ff),
      .stamp_q  (ram_q),
      .acc      (alu_acc),
      .hits     (alu_hits)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;

   // Read data for the address issued in one scan cycle arrives the next.
   assign cmp_pending_in = (state_ff == S_SCAN);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ok_in        = ok_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      alu_ctrl.op  = ALU_IDLE;
      alu_ctrl.sel = SEL_MIN;
      ram_we       = 1'b0;
      changed      = 1'b0;
      accepted     = 1'b0;
      idx          = LW'(alu_hits) - LW'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in  = req_data;
               addr_in = '0;
               unique case (req_data.func)
                  FUNC_ADD: begin
                     ok_in    = (req_data.seconds <= MAX_SECONDS) &&
                                (count_ff != CW'(DEPTH));
                     state_in = ok_in ? S_MIN : S_DONE;
                  end
                  FUNC_QUERY: begin
                     ok_in       = (count_ff != '0);
                     state_in    = ok_in ? S_SCAN : S_DONE;
                     alu_ctrl.op = ALU_CLR;
                  end
                  default: begin
                     ok_in    = 1'b0;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MIN: begin
            alu_ctrl.op  = ALU_MUL;
            alu_ctrl.sel = SEL_MIN;
            state_in     = S_SEC;
         end
         S_SEC: begin
            alu_ctrl.op  = ALU_MAC;
            alu_ctrl.sel = SEL_SEC;
            state_in     = S_MS;
         end
         S_MS: begin
            alu_ctrl.op  = ALU_MAC;
            alu_ctrl.sel = SEL_MS;
            state_in     = S_WRITE;
         end
         S_WRITE: begin
            ram_we   = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (cmp_pending_ff) begin
               alu_ctrl.op = ALU_CMP;
            end
            addr_in = addr_ff + AW'(1);
            if (CW'(addr_ff) + CW'(1) == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            alu_ctrl.op = ALU_CMP;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               unique case (req_ff.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                     cur_in   = {LW{1'b1}};
                  end
                  FUNC_ADD: begin
                     if (ok_ff) begin
                        count_in = count_ff + CW'(1);
                        accepted = 1'b1;
                     end
                  end
                  FUNC_QUERY: begin
                     if (ok_ff && (idx != cur_ff)) begin
                        cur_in  = idx;
                        changed = 1'b1;
                     end
                  end
                  default: ;
               endcase
               rsp_in.line_index  = LINE_W'(cur_in);
               rsp_in.changed     = changed;
               rsp_in.accepted    = accepted;
               rsp_in.entry_count = COUNT_W'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         cur_ff         <= {LW{1'b1}};
         cmp_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         cur_ff         <= cur_in;
         cmp_pending_ff <= cmp_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ok_ff   <= ok_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds table depth");

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < CW'(DEPTH)))
      else $error("table write with a full table");

   a_empty_no_line: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (cur_ff == {LW{1'b1}}))
      else $error("current line set while the table is empty");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(addr_ff) < count_ff))
      else $error("scan address beyond stored entries");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.changed && rsp_ff.accepted))
      else $error("response flags changed and accepted both set");

endmodule
